/* hw/rtl/timed_wait_queue_assert.svh */
// Assertion macros for the timed wait queue.
// Included by the top level; needs nothing else.
`ifndef TIMED_WAIT_QUEUE_ASSERT_SVH
`define TIMED_WAIT_QUEUE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define TWQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timed_wait_queue assertion failed");

// Property that must hold in the cycle after its trigger.
`define TWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timed_wait_queue assertion failed");

`endif

/* hw/rtl/twq_pkg.sv */
// Constants and types for the timed wait queue.
// Used by timed_wait_queue; depends on nothing.
package twq_pkg;

   localparam int unsigned CAPACITY_DEF = 16;
   localparam int unsigned MAX_OUT      = 16;
   localparam int unsigned MAX_OUT_W    = $clog2(MAX_OUT + 1);
   localparam int unsigned ID_W         = 16;
   localparam int unsigned TMO_W        = 16;
   localparam logic [TMO_W-1:0] NO_TIMEOUT = 16'hFFFF;

   // request kinds
   localparam logic [2:0] KIND_APPEND  = 3'd0;
   localparam logic [2:0] KIND_TAKE    = 3'd1;
   localparam logic [2:0] KIND_REMOVE  = 3'd2;
   localparam logic [2:0] KIND_FIND    = 3'd3;
   localparam logic [2:0] KIND_REL_ALL = 3'd4;
   localparam logic [2:0] KIND_TICK    = 3'd5;

   // result kinds
   localparam logic [2:0] RES_DONE     = 3'd0;
   localparam logic [2:0] RES_RELEASED = 3'd1;
   localparam logic [2:0] RES_FOUND    = 3'd2;
   localparam logic [2:0] RES_MISSING  = 3'd3;
   localparam logic [2:0] RES_FULL     = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RD   = 4'b0010,
      ST_PROC = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

endpackage

/* hw/rtl/timed_wait_queue.sv */
// Timed wait queue: ordered list of blocked thread IDs with timeouts.
// Depends on twq_pkg and timed_wait_queue_assert.svh.
//
//   channel | ports                                   | direction
//   req     | req_valid/req_stall, kind, id, ticks    | in
//   rsp     | rsp_valid/rsp_stall, kind, id, flags    | out
//   csr     | csr_valid/csr_ready, csr_list_role      | in
//
// Append, and kinds with nothing to walk, go straight to the finish state
// and wait there for the output. Other kinds walk the list through the
// RAM read port, reading (ST_RD) and then processing (ST_PROC) each entry.
// A release waits in the walk while the previous one cannot leave the
// output register. Reset clears control only; the RAM is not cleared.
`include "timed_wait_queue_assert.svh"

module timed_wait_queue
   import twq_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_kind,
   input  logic [ID_W-1:0]   req_thread_id,
   input  logic [TMO_W-1:0]  req_wait_ticks,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_result_kind,
   output logic [ID_W-1:0]   rsp_thread_id_res,
   output logic              rsp_timed_out,
   output logic              rsp_semaphore_release,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_list_role
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   // entry store: {id, timeout}
   logic [ID_W+TMO_W-1:0] mem [CAPACITY];
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [ID_W+TMO_W-1:0] mem_wd;
   logic [ID_W+TMO_W-1:0] rd_data_ff;

   state_type            state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic                 full_ff, full_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     wr_ff, wr_in;
   logic [MAX_OUT_W-1:0] n_ff, n_in;
   logic                 matched_ff, matched_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic                 pend_tmo_ff, pend_tmo_in;
   logic                 pend_sem_ff, pend_sem_in;
   logic                 list_role_ff, list_role_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_tmo_ff, rsp_tmo_in;
   logic                 rsp_sem_ff, rsp_sem_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [ID_W-1:0]      rd_id;
   logic [TMO_W-1:0]     rd_tmo, tmo_dec;
   logic                 under_max, rel_hit, drop_hit, find_hit, keep;
   logic                 rsp_free, proc_hold, last_entry, accept, walk_kind;
   logic [CNT_W-1:0]     wr_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rd_id   = rd_data_ff[ID_W+TMO_W-1:TMO_W];
   assign rd_tmo  = rd_data_ff[TMO_W-1:0];
   assign tmo_dec = (rd_tmo != NO_TIMEOUT && rd_tmo != '0) ? rd_tmo - TMO_W'(1) : rd_tmo;

   assign under_max  = n_ff < MAX_OUT_W'(MAX_OUT);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign last_entry = (j_ff + CNT_W'(1)) == count_ff;
   assign walk_kind  = (req_kind == KIND_TAKE) || (req_kind == KIND_REMOVE) ||
                       (req_kind == KIND_FIND) || (req_kind == KIND_REL_ALL) ||
                       (req_kind == KIND_TICK);

   // per-entry decision during the walk
   always_comb begin
      rel_hit  = 1'b0;
      drop_hit = 1'b0;
      find_hit = 1'b0;
      unique case (kind_ff)
         KIND_TAKE:    rel_hit  = (j_ff == '0);
         KIND_REL_ALL: rel_hit  = under_max;
         KIND_TICK:    rel_hit  = (tmo_dec == '0) && under_max;
         KIND_REMOVE:  drop_hit = !matched_ff && (rd_id == id_ff);
         KIND_FIND:    find_hit = !matched_ff && (rd_id == id_ff);
         default: ;
      endcase
   end

   assign keep      = !rel_hit && !drop_hit;
   assign wr_next   = wr_ff + CNT_W'(keep);
   assign proc_hold = rel_hit && pend_valid_ff && !rsp_free;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      full_in       = full_ff;
      count_in      = count_ff;
      j_in          = j_ff;
      wr_in         = wr_ff;
      n_in          = n_ff;
      matched_in    = matched_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_tmo_in   = pend_tmo_ff;
      pend_sem_in   = pend_sem_ff;
      list_role_in  = (csr_valid && csr_ready) ? csr_list_role : list_role_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tmo_in    = rsp_tmo_ff;
      rsp_sem_in    = rsp_sem_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_wa        = count_ff[IDX_W-1:0];
      mem_wd        = {req_thread_id, req_wait_ticks};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in       = req_kind;
               id_in         = req_thread_id;
               full_in       = 1'b0;
               j_in          = '0;
               wr_in         = '0;
               n_in          = '0;
               matched_in    = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = ST_FIN;
               if (req_kind == KIND_APPEND) begin
                  if (count_ff < CNT_W'(CAPACITY)) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end else if (walk_kind && count_ff != '0) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_PROC;
         end
         ST_PROC: begin
            if (!proc_hold) begin
               if (rel_hit) begin
                  // previous release leaves; this one waits in case it is the final one
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RES_RELEASED;
                     rsp_id_in    = pend_id_ff;
                     rsp_tmo_in   = pend_tmo_ff;
                     rsp_sem_in   = pend_sem_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = rd_id;
                  pend_tmo_in   = (kind_ff == KIND_TICK);
                  pend_sem_in   = (kind_ff == KIND_REL_ALL) && list_role_ff;
                  n_in          = n_ff + MAX_OUT_W'(1);
               end
               if (keep) begin
                  mem_we = 1'b1;
                  mem_wa = wr_ff[IDX_W-1:0];
                  mem_wd = {rd_id, (kind_ff == KIND_TICK) ? tmo_dec : rd_tmo};
               end
               if (drop_hit || find_hit) begin
                  matched_in = 1'b1;
               end
               wr_in = wr_next;
               j_in  = j_ff + CNT_W'(1);
               if (last_entry) begin
                  count_in = wr_next;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_tmo_in    = 1'b0;
               rsp_sem_in    = 1'b0;
               rsp_id_in     = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               if (pend_valid_ff) begin
                  rsp_kind_in = RES_RELEASED;
                  rsp_id_in   = pend_id_ff;
                  rsp_tmo_in  = pend_tmo_ff;
                  rsp_sem_in  = pend_sem_ff;
               end else begin
                  unique case (kind_ff)
                     KIND_APPEND: begin
                        rsp_kind_in = full_ff ? RES_FULL : RES_DONE;
                        rsp_id_in   = full_ff ? '0 : id_ff;
                     end
                     KIND_TAKE: rsp_kind_in = RES_MISSING;
                     KIND_REMOVE: begin
                        rsp_kind_in = matched_ff ? RES_DONE : RES_MISSING;
                        rsp_id_in   = matched_ff ? id_ff : '0;
                     end
                     KIND_FIND: begin
                        rsp_kind_in = matched_ff ? RES_FOUND : RES_MISSING;
                        rsp_id_in   = matched_ff ? id_ff : '0;
                     end
                     default: rsp_kind_in = RES_DONE;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         j_ff          <= '0;
         wr_ff         <= '0;
         n_ff          <= '0;
         matched_ff    <= 1'b0;
         full_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         list_role_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         j_ff          <= j_in;
         wr_ff         <= wr_in;
         n_ff          <= n_in;
         matched_ff    <= matched_in;
         full_ff       <= full_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         list_role_ff  <= list_role_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      pend_id_ff  <= pend_id_in;
      pend_tmo_ff <= pend_tmo_in;
      pend_sem_ff <= pend_sem_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_tmo_ff  <= rsp_tmo_in;
      rsp_sem_ff  <= rsp_sem_in;
      rsp_last_ff <= rsp_last_in;
   end

   // entry RAM with one write and one read port, registered read at the walk index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[j_ff[IDX_W-1:0]];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_kind_ff;
   assign rsp_thread_id_res     = rsp_id_ff;
   assign rsp_timed_out         = rsp_tmo_ff;
   assign rsp_semaphore_release = rsp_sem_ff;
   assign rsp_last              = rsp_last_ff;

   `TWQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `TWQ_ASSERT_NOW(a_rel_bound, clock, reset, 1'b1, n_ff <= MAX_OUT_W'(MAX_OUT))
   `TWQ_ASSERT_NOW(a_pend_in_walk, clock, reset, pend_valid_ff, state_ff != ST_IDLE)
   `TWQ_ASSERT_NEXT(a_walk_start, clock, reset, accept && walk_kind && count_ff != '0, state_ff == ST_RD)

endmodule

/* test/timed_wait_queue_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for timed_wait_queue: a clocked driver and monitor
// around a local model of the wait queue, with randomised gaps and stalls.
// Depends on twq_pkg and the timed_wait_queue RTL.
module timed_wait_queue_test;
   import twq_pkg::*;

   localparam logic [2:0] KIND_RSVD6 = 3'd6;
   localparam logic [2:0] KIND_RSVD7 = 3'd7;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned HOLDOFF_CYCLES = 300;

   typedef struct packed {
      logic [2:0]       kind;
      logic [ID_W-1:0]  thread_id;
      logic [TMO_W-1:0] wait_ticks;
   } wait_request_type;

   typedef struct packed {
      logic [2:0]      result_kind;
      logic [ID_W-1:0] thread_id_res;
      logic            timed_out;
      logic            semaphore_release;
      logic            last;
   } wait_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_kind = '0;
   logic [ID_W-1:0]   req_thread_id = '0;
   logic [TMO_W-1:0]  req_wait_ticks = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_result_kind;
   logic [ID_W-1:0]   rsp_thread_id_res;
   logic              rsp_timed_out;
   logic              rsp_semaphore_release;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_list_role = 1'b0;

   // model of the queue contents and the role register
   logic [ID_W-1:0]  queued_ids [CAPACITY_DEF];
   logic [TMO_W-1:0] queued_ticks [CAPACITY_DEF];
   int unsigned      queued_count = 0;
   logic             model_role = 1'b0;

   wait_request_type pending_requests [$];
   wait_result_type  expected_results [$];
   wait_request_type offer_item = '0;
   wait_result_type  want;
   bit            offered = 1'b0;
   logic          rsp_hold = 1'b0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;

   int unsigned mismatch_count = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count = 0;
   int unsigned expiry_count = 0;
   int unsigned full_count = 0;
   int unsigned role_writes = 0;

   timed_wait_queue i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_thread_id         (req_thread_id),
      .req_wait_ticks        (req_wait_ticks),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_thread_id_res     (rsp_thread_id_res),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_semaphore_release (rsp_semaphore_release),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_list_role         (csr_list_role)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic wait_result_type make_result(logic [2:0] kind, logic [ID_W-1:0] id,
                                                   logic tmo, logic sem);
      wait_result_type r;
      r.result_kind       = kind;
      r.thread_id_res     = id;
      r.timed_out         = tmo;
      r.semaphore_release = sem;
      r.last              = 1'b0;
      return r;
   endfunction

   function automatic int locate_id(logic [ID_W-1:0] id);
      for (int unsigned j = 0; j < queued_count; j++)
         if (queued_ids[j] == id)
            return int'(j);
      return -1;
   endfunction

   // close up the queue over one entry
   task automatic drop_entry(int unsigned pos);
      for (int unsigned j = pos; j + 1 < queued_count; j++) begin
         queued_ids[j]   = queued_ids[j + 1];
         queued_ticks[j] = queued_ticks[j + 1];
      end
      queued_count--;
   endtask

   task automatic predict_request(wait_request_type r);
      wait_result_type  res [$];
      int               pos;
      int unsigned      keep;
      logic [TMO_W-1:0] t;
      case (r.kind)
         KIND_APPEND: begin
            if (queued_count >= CAPACITY_DEF) begin
               res.push_back(make_result(RES_FULL, '0, 1'b0, 1'b0));
            end else begin
               queued_ids[queued_count]   = r.thread_id;
               queued_ticks[queued_count] = r.wait_ticks;
               queued_count++;
               res.push_back(make_result(RES_DONE, r.thread_id, 1'b0, 1'b0));
            end
         end
         KIND_TAKE: begin
            if (queued_count == 0) begin
               res.push_back(make_result(RES_MISSING, '0, 1'b0, 1'b0));
            end else begin
               res.push_back(make_result(RES_RELEASED, queued_ids[0], 1'b0, 1'b0));
               drop_entry(0);
            end
         end
         KIND_REMOVE: begin
            pos = locate_id(r.thread_id);
            if (pos < 0) begin
               res.push_back(make_result(RES_MISSING, '0, 1'b0, 1'b0));
            end else begin
               drop_entry(pos);
               res.push_back(make_result(RES_DONE, r.thread_id, 1'b0, 1'b0));
            end
         end
         KIND_FIND: begin
            pos = locate_id(r.thread_id);
            if (pos < 0)
               res.push_back(make_result(RES_MISSING, '0, 1'b0, 1'b0));
            else
               res.push_back(make_result(RES_FOUND, r.thread_id, 1'b0, 1'b0));
         end
         KIND_REL_ALL: begin
            while (queued_count > 0 && res.size() < MAX_OUT) begin
               res.push_back(make_result(RES_RELEASED, queued_ids[0], 1'b0, model_role));
               drop_entry(0);
            end
            if (res.size() == 0)
               res.push_back(make_result(RES_DONE, '0, 1'b0, 1'b0));
         end
         KIND_TICK: begin
            keep = 0;
            for (int unsigned j = 0; j < queued_count; j++) begin
               t = queued_ticks[j];
               if (t != NO_TIMEOUT && t != '0)
                  t = t - TMO_W'(1);
               // entries past the per-item release limit stay at zero
               if (t == '0 && res.size() < MAX_OUT) begin
                  res.push_back(make_result(RES_RELEASED, queued_ids[j], 1'b1, 1'b0));
               end else begin
                  queued_ids[keep]   = queued_ids[j];
                  queued_ticks[keep] = t;
                  keep++;
               end
            end
            queued_count = keep;
            if (res.size() == 0)
               res.push_back(make_result(RES_DONE, '0, 1'b0, 1'b0));
         end
         default: begin
            res.push_back(make_result(RES_DONE, '0, 1'b0, 1'b0));
         end
      endcase
      res[res.size() - 1].last = 1'b1;
      foreach (res[k])
         expected_results.push_back(res[k]);
   endtask

   task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] exp_v);
      mismatch_count++;
      $display("MISMATCH at %0t: %s: got %0h, expected %0h", $time, what, got, exp_v);
   endtask

   // driver: holds the offered item until the transfer completes
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(offer_item);
            offered = 1'b0;
            accepted_count++;
         end
         if (!offered && pending_requests.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            offer_item = pending_requests.pop_front();
            offered = 1'b1;
         end
         req_valid      <= offered;
         req_kind       <= offer_item.kind;
         req_thread_id  <= offer_item.thread_id;
         req_wait_ticks <= offer_item.wait_ticks;
      end
   end

   // monitor: compares each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_thread_id_res, '0);
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (want.timed_out)
                  expiry_count++;
               if (want.result_kind == RES_FULL)
                  full_count++;
               if (rsp_result_kind !== want.result_kind)
                  report_mismatch("result_kind", ID_W'(rsp_result_kind),
                                  ID_W'(want.result_kind));
               if (rsp_thread_id_res !== want.thread_id_res)
                  report_mismatch("thread_id_res", rsp_thread_id_res, want.thread_id_res);
               if (rsp_timed_out !== want.timed_out)
                  report_mismatch("timed_out", ID_W'(rsp_timed_out), ID_W'(want.timed_out));
               if (rsp_semaphore_release !== want.semaphore_release)
                  report_mismatch("semaphore_release", ID_W'(rsp_semaphore_release),
                                  ID_W'(want.semaphore_release));
               if (rsp_last !== want.last)
                  report_mismatch("last", ID_W'(rsp_last), ID_W'(want.last));
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic queue_request(logic [2:0] kind, logic [ID_W-1:0] id, logic [TMO_W-1:0] ticks);
      wait_request_type r;
      r.kind       = kind;
      r.thread_id  = id;
      r.wait_ticks = ticks;
      pending_requests.push_back(r);
   endtask

   // mostly well-formed traffic over a small ID pool so that finds, removals
   // and expiries hit; the odd full-range value and stray kind as noise
   task automatic queue_random_request();
      int unsigned      pick;
      logic [2:0]       kind;
      logic [ID_W-1:0]  id;
      logic [TMO_W-1:0] ticks;
      pick = $urandom_range(99);
      if (pick < 36)      kind = KIND_APPEND;
      else if (pick < 62) kind = KIND_TICK;
      else if (pick < 70) kind = KIND_TAKE;
      else if (pick < 80) kind = KIND_REMOVE;
      else if (pick < 90) kind = KIND_FIND;
      else if (pick < 95) kind = KIND_REL_ALL;
      else                kind = 3'($urandom_range(7));
      if ($urandom_range(7) == 0)
         id = ID_W'($urandom);
      else
         id = ID_W'($urandom_range(7));
      pick = $urandom_range(99);
      if (pick < 60)      ticks = TMO_W'($urandom_range(6, 1));
      else if (pick < 75) ticks = NO_TIMEOUT;
      else if (pick < 80) ticks = '0;
      else                ticks = TMO_W'($urandom);
      queue_request(kind, id, ticks);
   endtask

   // stimulus side runs on the falling edge, away from the driver
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || offered || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_list_role(logic role);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_list_role <= role;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      csr_valid  <= 1'b0;
      model_role = role;
      role_writes++;
      @(negedge clock);
   endtask

   task automatic run_random_phase(int unsigned count, int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) queue_random_request();
      wait_until_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_list_role(1'b0);

      // directed: empty queue, stray kinds, zero timeout, duplicates
      queue_request(KIND_TAKE, '0, 16'd1);
      queue_request(KIND_REL_ALL, '0, 16'd1);
      queue_request(KIND_TICK, 16'hFFFF, 16'hFFFF);
      queue_request(KIND_FIND, '0, 16'd1);
      queue_request(KIND_REMOVE, 16'hFFFF, 16'd1);
      queue_request(KIND_RSVD6, 16'h5555, 16'hAAAA);
      queue_request(KIND_RSVD7, 16'hAAAA, 16'h5555);
      queue_request(KIND_APPEND, '0, '0);
      queue_request(KIND_APPEND, 16'hFFFF, NO_TIMEOUT);
      queue_request(KIND_APPEND, 16'h1234, 16'd5);
      queue_request(KIND_APPEND, 16'h1234, 16'd1);
      queue_request(KIND_FIND, 16'h1234, 16'd1);
      // later duplicate expires, earlier one must stay
      queue_request(KIND_TICK, '0, 16'd1);
      queue_request(KIND_FIND, 16'h1234, 16'd1);
      queue_request(KIND_APPEND, 16'h8001, 16'hFFFE);
      queue_request(KIND_REMOVE, 16'h1234, 16'd1);
      queue_request(KIND_FIND, 16'h1234, 16'd1);
      queue_request(KIND_TAKE, '0, 16'd1);
      queue_request(KIND_TICK, '0, 16'd1);
      queue_request(KIND_REL_ALL, '0, 16'd1);
      run_random_phase(0, 0, 0);

      // receiver holds off while the sender keeps offering: queue full,
      // a full release-all and a tick that expires every entry at once
      write_list_role(1'b1);
      fork
         begin
            @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (CAPACITY_DEF + 1) queue_request(KIND_APPEND, ID_W'($urandom), NO_TIMEOUT);
      queue_request(KIND_REL_ALL, ID_W'($urandom), TMO_W'($urandom));
      repeat (CAPACITY_DEF) queue_request(KIND_APPEND, ID_W'($urandom), 16'd1);
      queue_request(KIND_TICK, ID_W'($urandom), TMO_W'($urandom));
      queue_request(KIND_TICK, ID_W'($urandom), TMO_W'($urandom));
      run_random_phase(0, 0, 0);

      write_list_role(1'b0);
      run_random_phase(81, 78, 0);
      write_list_role(1'b1);
      run_random_phase(81, 0, 78);
      write_list_role(1'b0);
      run_random_phase(81, 19, 19);
      write_list_role(1'b1);
      run_random_phase(81, 0, 0);

      $display("Covered %0d requests and %0d results over %0d list_role writes,",
               accepted_count, checked_count, role_writes);
      $display("including %0d timeout releases and %0d queue-full replies.",
               expiry_count, full_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4_800_000;
      $display("Timed out with %0d results outstanding", expected_results.size());
      $display("simulation failed");
      $finish;
   end

endmodule
